// File: hdl/bafd_pkg.sv
// ============================================================================
// bafd_pkg: shared definitions for the adaptive finite-difference block
// Register codes, stencil kinds, sideband structs and width helpers used by
// the sample window, the stencil pipeline, the divider cells and the top level.
// ============================================================================
`default_nettype none

package bafd_pkg;

    // Default sizing of the block.
    localparam int DEF_MAX_POINTS  = 4096;
    localparam int DEF_SAMPLE_BITS = 24;

    // Fixed field widths.
    localparam int LP_W      = 13;
    localparam int IDX_W     = 12;
    localparam int OUT_W     = 48;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_POINTS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_ORDER = 1'b1;

    localparam logic [LP_W-1:0] LINE_POINTS_RST = 13'd64;
    localparam int              MIN_POINTS      = 3;

    // Sample window: nine taps, the point of interest sits in the middle.
    localparam int WIN_DEPTH = 9;
    localparam int WIN_MID   = 4;

    // All stencils are brought to a common denominator before scaling.
    localparam int DEN      = 840;
    localparam int DEN_HALF = 420;

    // Divider cells retire this many quotient bits each.
    localparam int DIV_STEP = 4;
    // Partial remainder width: holds twice the denominator.
    localparam int REM_W    = 11;

    // Stencil selected by the distance to the nearer end of the line.
    typedef enum logic [2:0] {
        K_LEFT,
        K_RIGHT,
        K_C2,
        K_C4,
        K_C6,
        K_C8
    } t_kind;

    // Result sideband that follows a point down the pipeline.
    typedef struct packed {
        logic [IDX_W-1:0] point_index;
        logic             line_end;
    } t_tag;

    // One point handed from the sequencer to the stencil pipeline.
    typedef struct packed {
        logic  valid;
        t_kind kind;
        t_tag  tag;
    } t_job;

    // Sideband carried through the divider cells.
    typedef struct packed {
        logic neg;
        t_tag tag;
    } t_side;

    // Width of the scaled magnitude plus rounding offset.
    function automatic int prod_width(input int sample_bits, input int max_points);
        return sample_bits + 11 + $clog2(max_points) + 1;
    endfunction

endpackage

`default_nettype wire

// File: hdl/bafd_window.sv
// ============================================================================
// bafd_window: sample window
// A row of nine sample cells. On each shift every cell takes the value of its
// newer neighbor and the newest cell takes the incoming data.
// ============================================================================
`default_nettype none

module bafd_window #(
    parameter int SAMPLE_BITS = bafd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic signed [SAMPLE_BITS-1:0] i_data,
    output logic signed [SAMPLE_BITS-1:0] o_taps [bafd_pkg::WIN_DEPTH]
);

    logic signed [SAMPLE_BITS-1:0] r_win [bafd_pkg::WIN_DEPTH];

    // Each cell holds one sample and passes it toward the oldest end.
    for (genvar k = 0; k < bafd_pkg::WIN_DEPTH; k++) begin : g_cell
        if (k == bafd_pkg::WIN_DEPTH - 1) begin : g_head
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_win[k] <= '0;
                end else if (i_shift) begin
                    r_win[k] <= i_data;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_win[k] <= '0;
                end else if (i_shift) begin
                    r_win[k] <= r_win[k+1];
                end
            end
        end
    end

    assign o_taps = r_win;

endmodule

`default_nettype wire

// File: hdl/bafd_stencil.sv
// ============================================================================
// bafd_stencil: stencil numerator and scaling pipeline
// Forms the stencil differences, the numerator over the common denominator,
// its magnitude, and the magnitude times (N-1) plus the rounding offset.
// ============================================================================
`default_nettype none

module bafd_stencil #(
    parameter int SAMPLE_BITS = bafd_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_POINTS  = bafd_pkg::DEF_MAX_POINTS,
    localparam int SCW = $clog2(MAX_POINTS),
    localparam int PW  = bafd_pkg::prod_width(SAMPLE_BITS, MAX_POINTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  bafd_pkg::t_job                i_job,
    input  logic signed [SAMPLE_BITS-1:0] i_taps [bafd_pkg::WIN_DEPTH],
    input  logic [SCW-1:0]                i_scale,
    output logic                          o_valid,
    output logic [PW-1:0]                 o_prod,
    output bafd_pkg::t_side               o_side
);

    localparam int DW_D  = SAMPLE_BITS + 1;
    localparam int OS_W  = SAMPLE_BITS + 3;
    localparam int NUM_W = SAMPLE_BITS + 12;
    localparam int MAG_W = SAMPLE_BITS + 11;
    localparam int MID   = bafd_pkg::WIN_MID;

    // Stencil weights over the common denominator.
    localparam logic signed [NUM_W-1:0] K3   = NUM_W'(3);
    localparam logic signed [NUM_W-1:0] K14  = NUM_W'(14);
    localparam logic signed [NUM_W-1:0] K32  = NUM_W'(32);
    localparam logic signed [NUM_W-1:0] K70  = NUM_W'(70);
    localparam logic signed [NUM_W-1:0] K126 = NUM_W'(126);
    localparam logic signed [NUM_W-1:0] K168 = NUM_W'(168);
    localparam logic signed [NUM_W-1:0] K420 = NUM_W'(420);
    localparam logic signed [NUM_W-1:0] K560 = NUM_W'(560);
    localparam logic signed [NUM_W-1:0] K630 = NUM_W'(630);
    localparam logic signed [NUM_W-1:0] K672 = NUM_W'(672);

    // Stage 1: taps and job captured.
    logic                          r1_valid;
    bafd_pkg::t_kind               r1_kind;
    bafd_pkg::t_tag                r1_tag;
    logic signed [SAMPLE_BITS-1:0] r1_taps [bafd_pkg::WIN_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_job.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_kind <= i_job.kind;
            r1_tag  <= i_job.tag;
            r1_taps <= i_taps;
        end
    end

    // Stage 2: symmetric differences and the one-sided sums.
    logic signed [DW_D-1:0] n_d [4];
    logic signed [OS_W-1:0] n_osl;
    logic signed [OS_W-1:0] n_osr;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_d[k] = DW_D'(r1_taps[MID+1+k]) - DW_D'(r1_taps[MID-1-k]);
        end
        n_osl = (OS_W'(r1_taps[MID+1]) <<< 2) - (OS_W'(r1_taps[MID]) <<< 1)
              - OS_W'(r1_taps[MID]) - OS_W'(r1_taps[MID+2]);
        n_osr = OS_W'(r1_taps[MID-2]) - (OS_W'(r1_taps[MID-1]) <<< 2)
              + (OS_W'(r1_taps[MID]) <<< 1) + OS_W'(r1_taps[MID]);
    end

    logic                   r2_valid;
    bafd_pkg::t_kind        r2_kind;
    bafd_pkg::t_tag         r2_tag;
    logic signed [DW_D-1:0] r2_d [4];
    logic signed [OS_W-1:0] r2_osl;
    logic signed [OS_W-1:0] r2_osr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_kind <= r1_kind;
            r2_tag  <= r1_tag;
            r2_d    <= n_d;
            r2_osl  <= n_osl;
            r2_osr  <= n_osr;
        end
    end

    // Stage 3: numerator over the denominator 840.
    logic signed [NUM_W-1:0] e1, e2, e3, e4, n_num;

    always_comb begin
        e1 = NUM_W'(r2_d[0]);
        e2 = NUM_W'(r2_d[1]);
        e3 = NUM_W'(r2_d[2]);
        e4 = NUM_W'(r2_d[3]);
        unique case (r2_kind)
            bafd_pkg::K_LEFT:  n_num = K420 * NUM_W'(r2_osl);
            bafd_pkg::K_RIGHT: n_num = K420 * NUM_W'(r2_osr);
            bafd_pkg::K_C2:    n_num = K420 * e1;
            bafd_pkg::K_C4:    n_num = K560 * e1 - K70 * e2;
            bafd_pkg::K_C6:    n_num = K630 * e1 - K126 * e2 + K14 * e3;
            bafd_pkg::K_C8:    n_num = K672 * e1 - K168 * e2 + K32 * e3 - K3 * e4;
            default:           n_num = '0;
        endcase
    end

    logic                    r3_valid;
    bafd_pkg::t_tag          r3_tag;
    logic signed [NUM_W-1:0] r3_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_tag <= r2_tag;
            r3_num <= n_num;
        end
    end

    // Stage 4: sign and magnitude.
    logic             r4_valid;
    bafd_pkg::t_side  r4_side;
    logic [MAG_W-1:0] r4_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_side.neg <= r3_num[NUM_W-1];
            r4_side.tag <= r3_tag;
            r4_mag      <= r3_num[NUM_W-1] ? MAG_W'(-r3_num) : MAG_W'(r3_num);
        end
    end

    // Stage 5: scale by N-1 and add half the denominator for rounding.
    logic            r5_valid;
    bafd_pkg::t_side r5_side;
    logic [PW-1:0]   r5_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_adv) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_side <= r4_side;
            r5_prod <= PW'(r4_mag) * PW'(i_scale) + PW'(bafd_pkg::DEN_HALF);
        end
    end

    assign o_valid = r5_valid;
    assign o_prod  = r5_prod;
    assign o_side  = r5_side;

endmodule

`default_nettype wire

// File: hdl/bafd_div_cell.sv
// ============================================================================
// bafd_div_cell: one cell of the divide-by-840 chain
// Restoring division by the common denominator. Each cell shifts a few
// dividend bits into the partial remainder and retires as many quotient bits.
// ============================================================================
`default_nettype none

module bafd_div_cell #(
    parameter int DW = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [bafd_pkg::REM_W-1:0]   i_rem,
    input  logic [DW-1:0]                i_quo,
    input  bafd_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [bafd_pkg::REM_W-1:0]   o_rem,
    output logic [DW-1:0]                o_quo,
    output bafd_pkg::t_side              o_side
);

    localparam int RW = bafd_pkg::REM_W;

    logic [RW-1:0] n_rem;
    logic [DW-1:0] n_quo;

    // Dividend bits leave the top of the word, quotient bits enter the bottom.
    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        for (int s = 0; s < bafd_pkg::DIV_STEP; s++) begin
            n_rem = {n_rem[RW-2:0], n_quo[DW-1]};
            n_quo = {n_quo[DW-2:0], 1'b0};
            if (n_rem >= RW'(bafd_pkg::DEN)) begin
                n_rem    = n_rem - RW'(bafd_pkg::DEN);
                n_quo[0] = 1'b1;
            end
        end
    end

    logic            r_valid;
    logic [RW-1:0]   r_rem;
    logic [DW-1:0]   r_quo;
    bafd_pkg::t_side r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: hdl/boundary_adaptive_fd_derivative.sv
// ============================================================================
// boundary_adaptive_fd_derivative: streaming first derivative of a grid line
// Throughput: one sample per cycle while the output is not stalled; the last sample
// of a line holds the input while the window sequencer issues the trailing points.
// The divider chain and stencil stages move one result per cycle unless a finished
// result is held. The scaled product is PW = 48 bits wide at default sizing.
// Reset clears position, sequencer, window and pipeline valids; N = 64, order 6.
// ============================================================================
`default_nettype none

module boundary_adaptive_fd_derivative #(
    parameter int MAX_POINTS  = bafd_pkg::DEF_MAX_POINTS,
    parameter int SAMPLE_BITS = bafd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bafd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bafd_pkg::LP_W-1:0]            i_cfg_data,
    // Sample channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    // Result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [bafd_pkg::OUT_W-1:0]    o_derivative,
    output logic [bafd_pkg::IDX_W-1:0]           o_point_index,
    output logic                                 o_line_end
);

    localparam int POS_W     = $clog2(MAX_POINTS);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int NW        = (bafd_pkg::LP_W > CNT_W) ? bafd_pkg::LP_W : CNT_W;
    localparam int PW        = bafd_pkg::prod_width(SAMPLE_BITS, MAX_POINTS);
    localparam int DIV_CELLS = (PW + bafd_pkg::DIV_STEP - 1) / bafd_pkg::DIV_STEP;
    localparam int DW        = DIV_CELLS * bafd_pkg::DIV_STEP;
    localparam int OUT_W     = bafd_pkg::OUT_W;
    localparam int EXT_W     = (DW > OUT_W) ? DW : OUT_W;

    localparam logic [2:0] OFF_FIRST = 3'd4;
    localparam logic [2:0] OFF_LAST  = 3'd0;

    localparam logic [EXT_W-1:0] SAT_POS = {{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic [EXT_W-1:0] SAT_NEG = SAT_POS + EXT_W'(1);

    // Configuration registers; the port is always ready.
    logic [bafd_pkg::LP_W-1:0] r_line_points;
    logic                      r_order;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_points <= bafd_pkg::LINE_POINTS_RST;
            r_order       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bafd_pkg::CFG_LINE_POINTS:    r_line_points <= i_cfg_data;
                bafd_pkg::CFG_INTERIOR_ORDER: r_order       <= i_cfg_data[0];
            endcase
        end
    end

    // Effective point count, clamped to the supported range.
    logic [NW-1:0]    lp_ext;
    logic [NW-1:0]    pts_eff;
    logic [POS_W-1:0] last_pos;

    always_comb begin
        lp_ext = NW'(r_line_points);
        if (lp_ext < NW'(bafd_pkg::MIN_POINTS)) begin
            pts_eff = NW'(bafd_pkg::MIN_POINTS);
        end else if (lp_ext > NW'(MAX_POINTS)) begin
            pts_eff = NW'(MAX_POINTS);
        end else begin
            pts_eff = lp_ext;
        end
        last_pos = POS_W'(pts_eff - NW'(1));
    end

    // The whole pipeline moves unless a finished result is held.
    logic r_out_valid;
    logic adv;

    assign adv = !(r_out_valid && i_out_stall);

    // Window sequencer: one point per sample once the window has filled, or a flush at the line end.
    logic             r_busy;
    logic [2:0]       r_off;
    logic [2:0]       r_first;
    logic             r_flush;
    logic [POS_W-1:0] r_base;
    logic [POS_W-1:0] r_pos;

    logic             last_step;
    logic             in_ready;
    logic             accept;
    logic             issue;
    logic             zero_shift;
    logic [POS_W-1:0] p_cur;

    assign last_step  = (r_off == (r_flush ? OFF_LAST : OFF_FIRST));
    assign in_ready   = adv && (!r_busy || last_step);
    assign accept     = i_in_valid && in_ready;
    assign issue      = r_busy && adv && (r_off <= r_first);
    assign zero_shift = r_busy && adv && !last_step;
    assign p_cur      = (r_pos > last_pos) ? last_pos : r_pos;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_off   <= OFF_FIRST;
            r_first <= OFF_FIRST;
            r_flush <= 1'b0;
            r_base  <= '0;
            r_pos   <= '0;
        end else if (accept) begin
            r_base <= p_cur;
            r_off  <= OFF_FIRST;
            if (p_cur == last_pos) begin
                r_busy  <= 1'b1;
                r_flush <= 1'b1;
                r_first <= (p_cur >= POS_W'(OFF_FIRST)) ? OFF_FIRST : p_cur[2:0];
                r_pos   <= '0;
            end else begin
                r_busy  <= (p_cur >= POS_W'(OFF_FIRST));
                r_flush <= 1'b0;
                r_first <= OFF_FIRST;
                r_pos   <= p_cur + POS_W'(1);
            end
        end else if (r_busy && adv) begin
            if (last_step) begin
                r_busy <= 1'b0;
            end else begin
                r_off <= r_off - 3'd1;
            end
        end
    end

    // Sample window; zeros enter while a flush walks the center to the end.
    logic signed [SAMPLE_BITS-1:0] win_taps [bafd_pkg::WIN_DEPTH];

    bafd_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (accept || zero_shift),
        .i_data  (accept ? i_sample : '0),
        .o_taps  (win_taps)
    );

    // Stencil choice from the distance to the nearer end.
    logic [POS_W-1:0] pt;
    logic [POS_W-1:0] dr;
    logic [POS_W-1:0] near_dist;
    bafd_pkg::t_job   job;

    always_comb begin
        pt        = r_base - POS_W'(r_off);
        dr        = last_pos - pt;
        near_dist = (pt < dr) ? pt : dr;
        priority if (pt == '0) begin
            job.kind = bafd_pkg::K_LEFT;
        end else if (dr == '0) begin
            job.kind = bafd_pkg::K_RIGHT;
        end else if (near_dist == POS_W'(1)) begin
            job.kind = bafd_pkg::K_C2;
        end else if (near_dist == POS_W'(2)) begin
            job.kind = bafd_pkg::K_C4;
        end else if (near_dist == POS_W'(3) || !r_order) begin
            job.kind = bafd_pkg::K_C6;
        end else begin
            job.kind = bafd_pkg::K_C8;
        end
        job.valid            = issue;
        job.tag.point_index  = bafd_pkg::IDX_W'(pt);
        job.tag.line_end     = r_flush && (r_off == OFF_LAST);
    end

    // Numerator and scaling pipeline.
    logic            st_valid;
    logic [PW-1:0]   st_prod;
    bafd_pkg::t_side st_side;

    bafd_stencil #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_POINTS  (MAX_POINTS)
    ) u_stencil (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_job   (job),
        .i_taps  (win_taps),
        .i_scale (last_pos),
        .o_valid (st_valid),
        .o_prod  (st_prod),
        .o_side  (st_side)
    );

    // Divider chain: each cell hands its partial remainder to the next.
    logic                         c_valid [DIV_CELLS+1];
    logic [bafd_pkg::REM_W-1:0]   c_rem   [DIV_CELLS+1];
    logic [DW-1:0]                c_quo   [DIV_CELLS+1];
    bafd_pkg::t_side              c_side  [DIV_CELLS+1];

    assign c_valid[0] = st_valid;
    assign c_rem[0]   = '0;
    assign c_quo[0]   = DW'(st_prod);
    assign c_side[0]  = st_side;

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        bafd_div_cell #(
            .DW (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (c_valid[k]),
            .i_rem   (c_rem[k]),
            .i_quo   (c_quo[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    // Saturate the quotient magnitude and restore the sign.
    logic [EXT_W-1:0] q_ext;
    logic [EXT_W-1:0] q_sat;
    logic [OUT_W-1:0] n_deriv;

    always_comb begin
        q_ext = EXT_W'(c_quo[DIV_CELLS]);
        if (c_side[DIV_CELLS].neg) begin
            q_sat   = (q_ext > SAT_NEG) ? SAT_NEG : q_ext;
            n_deriv = -OUT_W'(q_sat);
        end else begin
            q_sat   = (q_ext > SAT_POS) ? SAT_POS : q_ext;
            n_deriv = OUT_W'(q_sat);
        end
    end

    // Output register.
    logic signed [OUT_W-1:0]          r_deriv;
    logic [bafd_pkg::IDX_W-1:0]       r_point_index;
    logic                             r_line_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= c_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_deriv       <= n_deriv;
            r_point_index <= c_side[DIV_CELLS].tag.point_index;
            r_line_end    <= c_side[DIV_CELLS].tag.line_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_derivative  = r_deriv;
    assign o_point_index = r_point_index;
    assign o_line_end    = r_line_end;

endmodule

`default_nettype wire
